// ===== sv/fjs_pkg.sv =====
package fjs_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_JAM_TORQUE_LIM      = 3'd0;
  localparam logic [2:0] REG_REVERSE_DURATION_MS = 3'd1;
  localparam logic [2:0] REG_BACKOFF_SPEED       = 3'd2;
  localparam logic [2:0] REG_FIRE_SPEED          = 3'd3;
  localparam logic [2:0] REG_SHOT_WINDOW_MS      = 3'd4;
  localparam logic [2:0] REG_SPINUP_DELAY_MS     = 3'd5;
  localparam logic [2:0] REG_WHEEL_SPEED_REF     = 3'd6;

  localparam int ADDR_W = 5;

  // reset values
  localparam logic [14:0] RST_JAM_TORQUE_LIM      = 15'd1536;
  localparam logic [15:0] RST_REVERSE_DURATION_MS = 16'd500;
  localparam logic [15:0] RST_BACKOFF_SPEED       = 16'hFB00;
  localparam logic [15:0] RST_FIRE_SPEED          = 16'd5120;
  localparam logic [15:0] RST_SHOT_WINDOW_MS      = 16'd80;
  localparam logic [15:0] RST_SPINUP_DELAY_MS     = 16'd150;
  localparam logic [16:0] RST_WHEEL_SPEED_REF     = 17'd80000;

  // feed mode codes
  localparam logic [1:0] MODE_STOP   = 2'd0;
  localparam logic [1:0] MODE_SINGLE = 2'd1;
  localparam logic [1:0] MODE_BURST  = 2'd2;

  typedef struct packed {
    logic [14:0]        jam_torque_lim;
    logic [15:0]        reverse_duration_ms;
    logic signed [15:0] backoff_speed;
    logic signed [15:0] fire_speed;
    logic [15:0]        shot_window_ms;
    logic [15:0]        spinup_delay_ms;
    logic [16:0]        wheel_speed_ref;
  } fjs_cfg_t;

  typedef struct packed {
    logic        reversing;
    logic [31:0] reverse_start;
    logic        shot_pending;
    logic        shot_active;
    logic [31:0] shot_start;
    logic        wheels_were_on;
    logic [31:0] wheels_on_start;
  } fjs_state_t;

  typedef struct packed {
    logic signed [15:0] feeder_speed;
    logic               wheel_update;
    logic [16:0]        wheel_ref;
    logic               wheel_enable;
    logic               jam_active;
  } fjs_result_t;

endpackage

// ===== sv/feeder_jam_and_shot_sequencer.sv =====
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | now_ms, wheels_requested, feed_mode, feeder_torque
// out     | output    | out_valid/out_stall| feeder_speed, wheel_update, wheel_ref,
//         |           |                    | wheel_enable, jam_active
// cfg     | input     | psel/penable/pwrite| paddr, pwdata, prdata, pready
//
// each transaction is held in the input register, then goes through the step
// logic into the result register
// one transaction per cycle sustained while out_stall is low; the step logic
// and the sequencer state registers are the only loop, closed on each advance
// rst_n is synchronous; it clears all sequencer state and loads the
// register defaults
// out_stall holds the result register; the input register, if empty, still takes
// one more transaction, then in_stall rises until the result is taken
module feeder_jam_and_shot_sequencer
  import fjs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          in_now_ms,
  input  logic                 in_wheels_requested,
  input  logic [1:0]           in_feed_mode,
  input  logic signed [15:0]   in_feeder_torque,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [15:0]   out_feeder_speed,
  output logic                 out_wheel_update,
  output logic [16:0]          out_wheel_ref,
  output logic                 out_wheel_enable,
  output logic                 out_jam_active,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  fjs_cfg_t           cfg;

  // input register
  logic               in_vld_r;
  logic [31:0]        now_ms_r;
  logic               wheels_req_r;
  logic [1:0]         feed_mode_r;
  logic signed [15:0] torque_r;

  // sequencer state
  fjs_state_t         st_r;
  fjs_state_t         st_nxt;

  // result register
  logic               out_vld_r;
  fjs_result_t        res_r;
  fjs_result_t        res_nxt;

  logic               advance;

  fjs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fjs_step u_step (
    .cfg              (cfg),
    .st               (st_r),
    .now_ms           (now_ms_r),
    .wheels_requested (wheels_req_r),
    .feed_mode        (feed_mode_r),
    .feeder_torque    (torque_r),
    .st_nxt           (st_nxt),
    .res              (res_nxt)
  );

  // the held transaction moves on when the result register is free or
  // being emptied this cycle
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      now_ms_r     <= in_now_ms;
      wheels_req_r <= in_wheels_requested;
      feed_mode_r  <= in_feed_mode;
      torque_r     <= in_feeder_torque;
    end
  end

  // state commits exactly once per transaction, in order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_feeder_speed = res_r.feeder_speed;
  assign out_wheel_update = res_r.wheel_update;
  assign out_wheel_ref    = res_r.wheel_ref;
  assign out_wheel_enable = res_r.wheel_enable;
  assign out_jam_active   = res_r.jam_active;

endmodule

// ===== sv/fjs_cfg.sv =====
module fjs_cfg
  import fjs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output fjs_cfg_t             cfg
);

  fjs_cfg_t   cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.jam_torque_lim      <= RST_JAM_TORQUE_LIM;
      cfg_r.reverse_duration_ms <= RST_REVERSE_DURATION_MS;
      cfg_r.backoff_speed       <= RST_BACKOFF_SPEED;
      cfg_r.fire_speed          <= RST_FIRE_SPEED;
      cfg_r.shot_window_ms      <= RST_SHOT_WINDOW_MS;
      cfg_r.spinup_delay_ms     <= RST_SPINUP_DELAY_MS;
      cfg_r.wheel_speed_ref     <= RST_WHEEL_SPEED_REF;
    end else if (wr_en) begin
      case (reg_idx)
        REG_JAM_TORQUE_LIM:      cfg_r.jam_torque_lim      <= pwdata[14:0];
        REG_REVERSE_DURATION_MS: cfg_r.reverse_duration_ms <= pwdata[15:0];
        REG_BACKOFF_SPEED:       cfg_r.backoff_speed       <= pwdata[15:0];
        REG_FIRE_SPEED:          cfg_r.fire_speed          <= pwdata[15:0];
        REG_SHOT_WINDOW_MS:      cfg_r.shot_window_ms      <= pwdata[15:0];
        REG_SPINUP_DELAY_MS:     cfg_r.spinup_delay_ms     <= pwdata[15:0];
        REG_WHEEL_SPEED_REF:     cfg_r.wheel_speed_ref     <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_JAM_TORQUE_LIM:      prdata = {17'd0, cfg_r.jam_torque_lim};
      REG_REVERSE_DURATION_MS: prdata = {16'd0, cfg_r.reverse_duration_ms};
      REG_BACKOFF_SPEED:       prdata = {16'd0, cfg_r.backoff_speed};
      REG_FIRE_SPEED:          prdata = {16'd0, cfg_r.fire_speed};
      REG_SHOT_WINDOW_MS:      prdata = {16'd0, cfg_r.shot_window_ms};
      REG_SPINUP_DELAY_MS:     prdata = {16'd0, cfg_r.spinup_delay_ms};
      REG_WHEEL_SPEED_REF:     prdata = {15'd0, cfg_r.wheel_speed_ref};
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

// ===== sv/fjs_step.sv =====
module fjs_step
  import fjs_pkg::*;
(
  input  fjs_cfg_t           cfg,
  input  fjs_state_t         st,
  input  logic [31:0]        now_ms,
  input  logic               wheels_requested,
  input  logic [1:0]         feed_mode,
  input  logic signed [15:0] feeder_torque,
  output fjs_state_t         st_nxt,
  output fjs_result_t        res
);

  logic        torque_over;
  logic [31:0] rev_elapsed;
  logic [31:0] spin_elapsed;
  logic [31:0] shot_elapsed;
  logic        spun_up;
  logic        run;

  // negative torque never trips, otherwise magnitude against threshold
  assign torque_over = !feeder_torque[15] && (feeder_torque[14:0] > cfg.jam_torque_lim);
  assign rev_elapsed = now_ms - st.reverse_start;

  always_comb begin
    st_nxt       = st;
    run          = 1'b0;
    spin_elapsed = 32'd0;
    shot_elapsed = 32'd0;
    spun_up      = 1'b0;
    res          = '0;

    if (feed_mode == MODE_SINGLE) begin
      st_nxt.shot_pending = 1'b1;
    end

    if (st.reversing || torque_over) begin
      if (st.reversing) begin
        if (rev_elapsed > {16'd0, cfg.reverse_duration_ms}) begin
          st_nxt.reversing = 1'b0;
        end
      end else begin
        st_nxt.reversing     = 1'b1;
        st_nxt.reverse_start = now_ms;
      end
      res.feeder_speed = cfg.backoff_speed;
      res.jam_active   = 1'b1;
    end else begin
      if (wheels_requested && !st.wheels_were_on) begin
        st_nxt.wheels_on_start = now_ms;
      end
      st_nxt.wheels_were_on = wheels_requested;

      spin_elapsed = now_ms - st_nxt.wheels_on_start;
      spun_up      = spin_elapsed >= {16'd0, cfg.spinup_delay_ms};

      if (wheels_requested) begin
        if (feed_mode == MODE_BURST) begin
          run                 = spun_up;
          st_nxt.shot_pending = 1'b0;
          st_nxt.shot_active  = 1'b0;
        end else begin
          if (st_nxt.shot_pending && !st.shot_active && spun_up) begin
            st_nxt.shot_pending = 1'b0;
            st_nxt.shot_active  = 1'b1;
            st_nxt.shot_start   = now_ms;
          end
          shot_elapsed = now_ms - st_nxt.shot_start;
          if (st_nxt.shot_active) begin
            if (shot_elapsed < {16'd0, cfg.shot_window_ms}) begin
              run = 1'b1;
            end else begin
              st_nxt.shot_active = 1'b0;
            end
          end
        end
      end else begin
        st_nxt.shot_pending = 1'b0;
        st_nxt.shot_active  = 1'b0;
      end

      res.feeder_speed = run ? cfg.fire_speed : 16'sd0;
      res.wheel_update = 1'b1;
      res.wheel_ref    = wheels_requested ? cfg.wheel_speed_ref : 17'd0;
      res.wheel_enable = wheels_requested;
    end
  end

endmodule
